[sv/shell_command_tokenizer_unit_macros.svh]
// Assertion macros shared by the tokenizer RTL files.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SHELL_COMMAND_TOKENIZER_UNIT_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SCTU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SCTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sctu_pkg.sv]
// Shared types and constants of the shell command tokenizer.
// Depends on nothing; used by every tokenizer module.
`default_nettype none

package sctu_pkg;

    // Token kinds on the result port
    localparam logic [4:0] K_CHAR  = 5'd0;
    localparam logic [4:0] K_WEND  = 5'd1;
    localparam logic [4:0] K_PIPE  = 5'd2;
    localparam logic [4:0] K_OR    = 5'd3;
    localparam logic [4:0] K_AMP   = 5'd4;
    localparam logic [4:0] K_AND   = 5'd5;
    localparam logic [4:0] K_SEMI  = 5'd6;
    localparam logic [4:0] K_LPAR  = 5'd7;
    localparam logic [4:0] K_RPAR  = 5'd8;
    localparam logic [4:0] K_OUT   = 5'd9;
    localparam logic [4:0] K_APP   = 5'd10;
    localparam logic [4:0] K_IN    = 5'd11;
    localparam logic [4:0] K_HERE  = 5'd12;
    localparam logic [4:0] K_NL    = 5'd13;
    localparam logic [4:0] K_END   = 5'd14;
    localparam logic [4:0] K_BADSQ = 5'd15;
    localparam logic [4:0] K_BADDQ = 5'd16;

    // Characters with special meaning
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_LPAR   = 8'h28;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_BSL    = 8'h5C;
    localparam logic [7:0] C_BTICK  = 8'h60;
    localparam logic [7:0] C_PIPE   = 8'h7C;

    // Result slots per bundle; one input byte causes at most two results
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // One result item
    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] wbyte;
    } t_res;

    // All results of one input byte, filled from slot 0
    typedef struct packed {
        logic [CNT_W-1:0]         count;
        t_res [MAX_RES-1:0]       res;
    } t_bundle;

endpackage

`default_nettype wire

[sv/sctu_front.sv]
// Front end: accepts text bytes, runs the lexer state and builds result bundles.
// Depends on sctu_pkg and the assertion macro header.
`default_nettype none
`include "shell_command_tokenizer_unit_macros.svh"

module sctu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_text_byte,
    input  wire logic            i_end_of_text,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output sctu_pkg::t_bundle    o_bundle
);
    import sctu_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_WBSL    = 3'd1,
        M_SQ      = 3'd2,
        M_DQ      = 3'd3,
        M_DQBSL   = 3'd4,
        M_COMMENT = 3'd5,
        M_PEND    = 3'd6
    } t_mode;

    t_mode       r_mode, n_mode;
    logic        r_hc, n_hc;     // word has seen a quote or a character
    logic        r_ne, n_ne;     // word has emitted a character
    logic [7:0]  r_pend, n_pend; // held operator byte
    logic        v_idle;
    logic        v_accept;
    t_bundle     v_b;

    // Append one result to a bundle; non-char kinds carry a zero byte
    function automatic t_bundle add_res(t_bundle b, logic [4:0] kind, logic [7:0] c);
        t_bundle r;
        r = b;
        r.res[b.count].kind  = kind;
        r.res[b.count].wbyte = (kind == K_CHAR) ? c : 8'd0;
        r.count = b.count + CNT_W'(1);
        return r;
    endfunction

    // Kind of the held operator, single or doubled
    function automatic logic [4:0] op_kind(logic [7:0] op, logic dbl);
        logic [4:0] k;
        unique case (op)
            C_PIPE:  k = dbl ? K_OR  : K_PIPE;
            C_AMP:   k = dbl ? K_AND : K_AMP;
            C_GT:    k = dbl ? K_APP : K_OUT;
            default: k = dbl ? K_HERE : K_IN;
        endcase
        return k;
    endfunction

    assign o_ready  = !i_q_full;
    assign v_accept = i_valid && o_ready;
    assign o_push   = v_accept && (v_b.count != '0);
    assign o_bundle = v_b;

    // Lexer step: next state and the results of this byte
    always_comb begin
        v_b    = '0;
        n_mode = r_mode;
        n_hc   = r_hc;
        n_ne   = r_ne;
        n_pend = r_pend;
        v_idle = 1'b0;
        if (i_end_of_text) begin
            unique case (r_mode)
                M_SQ: v_b = add_res(v_b, K_BADSQ, 8'd0);
                M_DQ, M_DQBSL: v_b = add_res(v_b, K_BADDQ, 8'd0);
                M_PEND: begin
                    v_b = add_res(v_b, op_kind(r_pend, 1'b0), 8'd0);
                    v_b = add_res(v_b, K_END, 8'd0);
                end
                M_COMMENT: v_b = add_res(v_b, K_END, 8'd0);
                default: begin
                    if (r_ne) v_b = add_res(v_b, K_WEND, 8'd0);
                    v_b = add_res(v_b, K_END, 8'd0);
                end
            endcase
            n_mode = M_IDLE;
            n_hc   = 1'b0;
            n_ne   = 1'b0;
            n_pend = 8'd0;
        end else begin
            unique case (r_mode)
                M_WBSL: begin
                    n_mode = M_IDLE;
                    if (i_text_byte != C_NL) begin
                        v_b  = add_res(v_b, K_CHAR, i_text_byte);
                        n_hc = 1'b1;
                        n_ne = 1'b1;
                    end
                end
                M_SQ: begin
                    if (i_text_byte == C_SQUOTE) begin
                        n_mode = M_IDLE;
                    end else begin
                        v_b  = add_res(v_b, K_CHAR, i_text_byte);
                        n_hc = 1'b1;
                        n_ne = 1'b1;
                    end
                end
                M_DQ: begin
                    if (i_text_byte == C_DQUOTE) begin
                        n_mode = M_IDLE;
                    end else if (i_text_byte == C_BSL) begin
                        n_mode = M_DQBSL;
                    end else begin
                        v_b  = add_res(v_b, K_CHAR, i_text_byte);
                        n_hc = 1'b1;
                        n_ne = 1'b1;
                    end
                end
                M_DQBSL: begin
                    n_mode = M_DQ;
                    if (i_text_byte == C_DQUOTE || i_text_byte == C_BSL ||
                        i_text_byte == C_DOLLAR || i_text_byte == C_BTICK) begin
                        v_b  = add_res(v_b, K_CHAR, i_text_byte);
                        n_hc = 1'b1;
                        n_ne = 1'b1;
                    end else if (i_text_byte != C_NL) begin
                        // backslash kept before a non-special byte
                        v_b  = add_res(v_b, K_CHAR, C_BSL);
                        v_b  = add_res(v_b, K_CHAR, i_text_byte);
                        n_hc = 1'b1;
                        n_ne = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_text_byte == C_NL) begin
                        v_b    = add_res(v_b, K_NL, 8'd0);
                        n_mode = M_IDLE;
                    end
                end
                M_PEND: begin
                    n_pend = 8'd0;
                    n_mode = M_IDLE;
                    if (i_text_byte == r_pend) begin
                        v_b = add_res(v_b, op_kind(r_pend, 1'b1), 8'd0);
                    end else begin
                        v_b    = add_res(v_b, op_kind(r_pend, 1'b0), 8'd0);
                        v_idle = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    v_idle = 1'b1;
                end
            endcase

            // Byte between tokens or inside an unquoted word
            if (v_idle) begin
                unique case (i_text_byte)
                    C_SPACE, C_TAB: begin
                        if (n_ne) v_b = add_res(v_b, K_WEND, 8'd0);
                        n_hc = 1'b0;
                        n_ne = 1'b0;
                    end
                    C_NL, C_SEMI, C_LPAR, C_RPAR: begin
                        if (n_ne) v_b = add_res(v_b, K_WEND, 8'd0);
                        n_hc = 1'b0;
                        n_ne = 1'b0;
                        unique case (i_text_byte)
                            C_NL:    v_b = add_res(v_b, K_NL, 8'd0);
                            C_SEMI:  v_b = add_res(v_b, K_SEMI, 8'd0);
                            C_LPAR:  v_b = add_res(v_b, K_LPAR, 8'd0);
                            default: v_b = add_res(v_b, K_RPAR, 8'd0);
                        endcase
                    end
                    C_PIPE, C_AMP, C_LT, C_GT: begin
                        if (n_ne) v_b = add_res(v_b, K_WEND, 8'd0);
                        n_hc   = 1'b0;
                        n_ne   = 1'b0;
                        n_pend = i_text_byte;
                        n_mode = M_PEND;
                    end
                    C_SQUOTE: begin
                        n_hc   = 1'b1;
                        n_mode = M_SQ;
                    end
                    C_DQUOTE: begin
                        n_hc   = 1'b1;
                        n_mode = M_DQ;
                    end
                    C_BSL: n_mode = M_WBSL;
                    C_HASH: begin
                        if (!n_hc) begin
                            if (n_ne) v_b = add_res(v_b, K_WEND, 8'd0);
                            n_ne   = 1'b0;
                            n_mode = M_COMMENT;
                        end else begin
                            v_b  = add_res(v_b, K_CHAR, i_text_byte);
                            n_ne = 1'b1;
                        end
                    end
                    default: begin
                        v_b  = add_res(v_b, K_CHAR, i_text_byte);
                        n_hc = 1'b1;
                        n_ne = 1'b1;
                    end
                endcase
            end
        end
    end

    // Lexer state, advanced on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hc   <= 1'b0;
            r_ne   <= 1'b0;
            r_pend <= 8'd0;
        end else if (v_accept) begin
            r_mode <= n_mode;
            r_hc   <= n_hc;
            r_ne   <= n_ne;
            r_pend <= n_pend;
        end
    end

    `SCTU_ASSERT_NEXT(a_eot_clears, i_clk, i_rst_n, v_accept && i_end_of_text,
        r_mode == M_IDLE && !r_hc && !r_ne && r_pend == 8'd0, "end of text left state")
    `SCTU_ASSERT_NOW(a_pend_only_held, i_clk, i_rst_n, r_mode != M_PEND,
        r_pend == 8'd0, "operator byte held outside pending mode")
    `SCTU_ASSERT_NOW(a_content_if_nonempty, i_clk, i_rst_n, r_ne,
        r_hc, "word has characters but no content flag")

endmodule

`default_nettype wire

[sv/sctu_fifo.sv]
// Bundle queue between the lexer front end and the result serializer.
// Depends on sctu_pkg and the assertion macro header.
`default_nettype none
`include "shell_command_tokenizer_unit_macros.svh"

module sctu_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sctu_pkg::t_bundle i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output sctu_pkg::t_bundle      o_data
);
    import sctu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_bundle              r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_QW-1:0]    r_count;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) r_count <= r_count + CNT_QW'(1);
            else if (i_pop && !i_push) r_count <= r_count - CNT_QW'(1);
        end
    end

    `SCTU_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, o_full, !i_push,
        "push into full queue")
    `SCTU_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, o_empty, !i_pop,
        "pop from empty queue")
    `SCTU_ASSERT_NOW(a_no_empty_bundle, i_clk, i_rst_n, i_push, i_data.count != '0,
        "bundle without results queued")

endmodule

`default_nettype wire

[sv/sctu_back.sv]
// Back end: sends the results of queued bundles one per cycle while i_ready is high.
// Depends on sctu_pkg and the assertion macro header.
`default_nettype none
`include "shell_command_tokenizer_unit_macros.svh"

module sctu_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire sctu_pkg::t_bundle i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [4:0]             o_token_kind,
    output logic [7:0]             o_word_byte,
    output logic                   o_last_of_run
);
    import sctu_pkg::*;

    t_bundle           r_cur;
    logic              r_have;
    logic [CNT_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [4:0]        r_kind;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              v_load;
    logic              v_cur_last;
    logic              v_fetch;

    // Load the output register when it is free or being drained
    assign v_load     = r_have && (!r_out_valid || i_ready);
    assign v_cur_last = (r_idx == r_cur.count - CNT_W'(1));
    assign v_fetch    = !r_have || (v_load && v_cur_last);
    assign o_pop      = v_fetch && !i_q_empty;

    assign o_valid       = r_out_valid;
    assign o_token_kind  = r_kind;
    assign o_word_byte   = r_byte;
    assign o_last_of_run = r_last;

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_q_data;
        if (v_load) begin
            r_kind <= r_cur.res[r_idx].kind;
            r_byte <= r_cur.res[r_idx].wbyte;
            r_last <= v_cur_last;
        end
    end

    // Bundle and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (v_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // a new bundle restarts the index; otherwise step through the current one
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (v_load) begin
                r_idx <= r_idx + CNT_W'(1);
                if (v_cur_last) r_have <= 1'b0;
            end
        end
    end

    `SCTU_ASSERT_NOW(a_idx_in_bundle, i_clk, i_rst_n, r_have, r_idx < r_cur.count,
        "result index past bundle")
    `SCTU_ASSERT_NOW(a_zero_byte, i_clk, i_rst_n, o_valid && o_token_kind != K_CHAR,
        o_word_byte == 8'd0, "non-char result with nonzero byte")
    `SCTU_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_have && r_idx == '0,
        "popped bundle not held")

endmodule

`default_nettype wire

[sv/shell_command_tokenizer_unit.sv]
// Shell command tokenizer: one text byte per request in, shell token results out.
// The front end updates the lexer state in the accepting cycle; each text byte
// that produces tokens queues one bundle of up to two results, and the back end
// sends them one per cycle while the receiver is ready, with last_of_run on the
// final one. Input is taken at one byte per cycle while the bundle queue
// (QUEUE_DEPTH entries) has room; sustained throughput is bounded by the output
// port at one result per cycle. A result passes through the bundle queue, the
// back end's bundle register and its output register. Bytes that produce nothing
// use no queue space. Depends on sctu_pkg, sctu_front, sctu_fifo and sctu_back.
`default_nettype none

module shell_command_tokenizer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_token_kind,
    output logic [7:0]       o_word_byte,
    output logic             o_last_of_run
);
    import sctu_pkg::*;

    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_bundle  w_push_data;
    t_bundle  w_pop_data;

    sctu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_bundle      (w_push_data)
    );

    sctu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_data)
    );

    sctu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_empty),
        .i_q_data      (w_pop_data),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_word_byte   (o_word_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

[tb/tb_shell_command_tokenizer_unit.sv]
// Self-checking testbench for shell_command_tokenizer_unit: text bytes go in from a request
// queue, token results are predicted in-line and compared as they leave the block.
// Depends on sctu_pkg and shell_command_tokenizer_unit.

module tb_shell_command_tokenizer_unit;
    import sctu_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int RUN_LIMIT    = 2_000_000;

    // Lexer states of the predictor
    typedef enum logic [2:0] {
        LX_PLAIN, LX_ESC, LX_SQ, LX_DQ, LX_DQ_ESC, LX_COMMENT, LX_OP_HELD
    } t_lex_mode;

    typedef struct packed {
        logic [7:0] tbyte;
        logic       eot;
    } t_text_req;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] wbyte;
        logic       last;
    } t_token;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_text_byte   = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [4:0] o_token_kind;
    logic [7:0] o_word_byte;
    logic       o_last_of_run;

    // Request and token stores
    t_text_req text_q[$];
    t_token    tok_q[$];
    t_token    run_q[$];

    // Predictor state
    t_lex_mode scan_mode    = LX_PLAIN;
    logic      word_seen    = 1'b0;
    logic      word_emitted = 1'b0;
    logic [7:0] held_op     = 8'h00;

    // Handshake and idling control
    logic  in_taken    = 1'b0;
    int    tx_idle_pct = 0;
    int    rx_stall_pct = 0;
    int    hold_asked  = 0;
    int    hold_taken  = 0;
    int    hold_left   = 0;

    // Bookkeeping
    int    n_items    = 0;
    int    n_accepted = 0;
    int    n_ends     = 0;
    int    n_tokens   = 0;
    int    n_mismatch = 0;
    logic [16:0] kinds_seen = '0;

    shell_command_tokenizer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_word_byte   (o_word_byte),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic log_mismatch(input string msg);
        n_mismatch++;
        $display("ERROR: %s", msg);
    endtask

    // ---------------- token predictor ----------------

    task automatic put_token(input logic [4:0] kind, input logic [7:0] b);
        t_token t;
        t.kind  = kind;
        t.wbyte = (kind == K_CHAR) ? b : 8'h00;
        t.last  = 1'b0;
        run_q.insert(run_q.size(), t);
    endtask

    task automatic put_char(input logic [7:0] b);
        put_token(K_CHAR, b);
        word_seen    = 1'b1;
        word_emitted = 1'b1;
    endtask

    // Close the current word; an empty word gives no word end
    task automatic close_word();
        if (word_emitted) begin
            put_token(K_WEND, 8'h00);
        end
        word_seen    = 1'b0;
        word_emitted = 1'b0;
    endtask

    task automatic release_op(input logic doubled);
        case (held_op)
            C_PIPE:  put_token(doubled ? K_OR  : K_PIPE, 8'h00);
            C_AMP:   put_token(doubled ? K_AND : K_AMP,  8'h00);
            C_GT:    put_token(doubled ? K_APP : K_OUT,  8'h00);
            default: put_token(doubled ? K_HERE : K_IN,  8'h00);
        endcase
        held_op   = 8'h00;
        scan_mode = LX_PLAIN;
    endtask

    // Byte seen between tokens or inside an unquoted word
    task automatic plain_byte(input logic [7:0] c);
        case (c)
            C_SPACE, C_TAB: close_word();
            C_NL: begin
                close_word();
                put_token(K_NL, 8'h00);
            end
            C_SEMI: begin
                close_word();
                put_token(K_SEMI, 8'h00);
            end
            C_LPAR: begin
                close_word();
                put_token(K_LPAR, 8'h00);
            end
            C_RPAR: begin
                close_word();
                put_token(K_RPAR, 8'h00);
            end
            C_PIPE, C_AMP, C_LT, C_GT: begin
                close_word();
                held_op   = c;
                scan_mode = LX_OP_HELD;
            end
            C_SQUOTE: begin
                word_seen = 1'b1;
                scan_mode = LX_SQ;
            end
            C_DQUOTE: begin
                word_seen = 1'b1;
                scan_mode = LX_DQ;
            end
            C_BSL: scan_mode = LX_ESC;
            C_HASH: begin
                if (!word_seen) begin
                    close_word();
                    scan_mode = LX_COMMENT;
                end else begin
                    put_char(c);
                end
            end
            default: put_char(c);
        endcase
    endtask

    function automatic logic dq_escapable(input logic [7:0] c);
        return (c == C_DQUOTE) || (c == C_BSL) || (c == C_DOLLAR) || (c == C_BTICK);
    endfunction

    // Advance the lexer by one accepted request and queue the tokens it yields
    task automatic lex_step(input logic [7:0] c, input logic eot);
        t_token t;
        run_q.delete();
        if (eot) begin
            case (scan_mode)
                LX_SQ:            put_token(K_BADSQ, 8'h00);
                LX_DQ, LX_DQ_ESC: put_token(K_BADDQ, 8'h00);
                LX_OP_HELD: begin
                    release_op(1'b0);
                    put_token(K_END, 8'h00);
                end
                LX_COMMENT:       put_token(K_END, 8'h00);
                default: begin
                    close_word();
                    put_token(K_END, 8'h00);
                end
            endcase
            scan_mode    = LX_PLAIN;
            word_seen    = 1'b0;
            word_emitted = 1'b0;
            held_op      = 8'h00;
        end else begin
            case (scan_mode)
                LX_ESC: begin
                    scan_mode = LX_PLAIN;
                    if (c != C_NL) begin
                        put_char(c);
                    end
                end
                LX_SQ: begin
                    if (c == C_SQUOTE) begin
                        scan_mode = LX_PLAIN;
                    end else begin
                        put_char(c);
                    end
                end
                LX_DQ: begin
                    if (c == C_DQUOTE) begin
                        scan_mode = LX_PLAIN;
                    end else if (c == C_BSL) begin
                        scan_mode = LX_DQ_ESC;
                    end else begin
                        put_char(c);
                    end
                end
                LX_DQ_ESC: begin
                    scan_mode = LX_DQ;
                    if (dq_escapable(c)) begin
                        put_char(c);
                    end else if (c != C_NL) begin
                        // backslash is kept before an ordinary byte
                        put_char(C_BSL);
                        put_char(c);
                    end
                end
                LX_COMMENT: begin
                    if (c == C_NL) begin
                        put_token(K_NL, 8'h00);
                        scan_mode = LX_PLAIN;
                    end
                end
                LX_OP_HELD: begin
                    if (c == held_op) begin
                        release_op(1'b1);
                    end else begin
                        release_op(1'b0);
                        plain_byte(c);
                    end
                end
                default: begin
                    scan_mode = LX_PLAIN;
                    plain_byte(c);
                end
            endcase
        end
        // mark the final token of this request
        if (run_q.size() > 0) begin
            t = run_q.pop_back();
            t.last = 1'b1;
            run_q.insert(run_q.size(), t);
        end
        foreach (run_q[i]) begin
            tok_q.insert(tok_q.size(), run_q[i]);
        end
    endtask

    // ---------------- stimulus building ----------------

    task automatic send_byte(input logic [7:0] b);
        t_text_req r;
        r.tbyte = b;
        r.eot   = 1'b0;
        text_q.insert(text_q.size(), r);
        n_items++;
    endtask

    // End marker; the byte lane carries junk
    task automatic send_end();
        t_text_req r;
        r.tbyte = 8'($urandom_range(0, 255));
        r.eot   = 1'b1;
        text_q.insert(text_q.size(), r);
        n_items++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // Mostly lowercase letters, sometimes any byte at all
    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] dq_pick();
        case ($urandom_range(0, 5))
            0:       return C_DQUOTE;
            1:       return C_BSL;
            2:       return C_DOLLAR;
            3:       return C_BTICK;
            4:       return C_NL;
            default: return word_char();
        endcase
    endfunction

    task automatic send_operator();
        logic [7:0] op;
        case ($urandom_range(0, 6))
            0:       op = C_PIPE;
            1:       op = C_AMP;
            2:       op = C_GT;
            3:       op = C_LT;
            4:       op = C_SEMI;
            5:       op = C_LPAR;
            default: op = C_RPAR;
        endcase
        send_byte(op);
        if ($urandom_range(0, 1) == 1) begin
            send_byte(op);
        end
    endtask

    // One well-formed command line with random content, sometimes left open at the end
    task automatic send_command();
        int n_tok;
        n_tok = $urandom_range(1, 6);
        repeat (n_tok) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 4)) send_byte(word_char());
                3: begin
                    send_byte(C_SQUOTE);
                    repeat ($urandom_range(0, 3)) send_byte(word_char());
                    send_byte(C_SQUOTE);
                end
                4: begin
                    send_byte(C_DQUOTE);
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(0, 1) == 1) begin
                            send_byte(C_BSL);
                            send_byte(dq_pick());
                        end else begin
                            send_byte(word_char());
                        end
                    end
                    send_byte(C_DQUOTE);
                end
                5: begin
                    send_byte(C_BSL);
                    send_byte(($urandom_range(0, 3) == 0) ? C_NL : word_char());
                end
                6: send_operator();
                7: send_byte(($urandom_range(0, 1) == 1) ? C_SPACE : C_TAB);
                8: begin
                    send_byte(C_HASH);
                    repeat ($urandom_range(0, 3)) send_byte(word_char());
                    send_byte(C_NL);
                end
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 2) == 0) begin
                send_byte(C_SPACE);
            end
        end
        case ($urandom_range(0, 7))
            0: begin
                send_byte(C_SQUOTE);
                send_byte(word_char());
            end
            1: begin
                send_byte(C_DQUOTE);
                send_byte(word_char());
            end
            2: send_byte(C_BSL);
            default: ;
        endcase
        send_end();
    endtask

    // Queue about n_new requests: commands, with a share of raw noise
    task automatic fill_random(input int n_new);
        int target;
        target = n_items + n_new;
        while (n_items < target) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                send_end();
            end else begin
                send_command();
            end
        end
    endtask

    task automatic wait_accepted();
        while (n_accepted < n_items) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        @(posedge i_clk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // ---------------- driver, receiver, monitor ----------------

    // Sender: offer the next request once the current one is taken
    always @(negedge i_clk) begin : drv_text
        t_text_req r;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (text_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                r = text_q.pop_front();
                i_valid       <= 1'b1;
                i_text_byte   <= r.tbyte;
                i_end_of_text <= r.eot;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Check tokens leaving the block, then predict from the request entering it
    always @(posedge i_clk) begin : mon_tokens
        t_token want;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_tokens++;
                kinds_seen[o_token_kind] = 1'b1;
                if (tok_q.size() == 0) begin
                    log_mismatch($sformatf("token %0d unexpected: kind %0d byte %02h last %0b",
                        n_tokens, o_token_kind, o_word_byte, o_last_of_run));
                end else begin
                    want = tok_q.pop_front();
                    if (o_token_kind !== want.kind || o_word_byte !== want.wbyte ||
                        o_last_of_run !== want.last) begin
                        log_mismatch($sformatf(
                            "token %0d: kind %0d byte %02h last %0b, wanted %0d %02h %0b",
                            n_tokens, o_token_kind, o_word_byte, o_last_of_run,
                            want.kind, want.wbyte, want.last));
                    end
                end
            end
            if (i_valid && o_ready) begin
                lex_step(i_text_byte, i_end_of_text);
                n_accepted++;
                if (i_end_of_text) begin
                    n_ends++;
                end
            end
        end
    end

    // ---------------- test sequence ----------------

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operator, doubled forms, extreme bytes, '#' inside a word
        send_byte(8'h00);
        send_byte(8'hFF);
        send_str("#|&><;");
        send_str("||&&>><<()");
        // comment at the start of a word, dropped up to the newline
        send_str("\t#c\n");
        // empty quoted word, then a trailing backslash dropped at end
        send_str("''\\");
        send_end();
        // line continuation, kept and escaped backslashes in double quotes, open quote
        send_str("\\\n\"\\q\\$");
        send_end();

        // No idling, with one long receiver hold-off while requests keep coming
        set_idling(0, 0);
        fill_random(60);
        hold_asked++;
        wait_accepted();

        set_idling(72, 0);
        fill_random(60);
        wait_accepted();

        set_idling(0, 72);
        fill_random(60);
        wait_accepted();

        set_idling(33, 33);
        fill_random(60);
        wait_accepted();

        while (tok_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d text requests (%0d end marks) and %0d checked tokens,",
            n_accepted, n_ends, n_tokens);
        $display("%0d of 17 token kinds seen over four sender/receiver idling mixes.",
            $countones(kinds_seen));
        if (n_mismatch == 0) begin
            $display("shell_command_tokenizer_unit: match");
        end else begin
            $display("shell_command_tokenizer_unit: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("Timeout: %0d tokens still expected", tok_q.size());
        $display("shell_command_tokenizer_unit: mismatch");
        $finish;
    end

endmodule
